/* design/qrap_pkg.sv */
// Shared types and constants for the quad rotation core.
package qrap_pkg;

  localparam int CoordW = 24;
  localparam int AngleW = 16;
  localparam int TrigW  = 16;
  localparam int CordW  = 36;
  localparam int AtanLen = 24;

  localparam logic signed [CordW-1:0] GainQ30   = 36'sd652032874;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [TrigW-1:0] TrigOne   = 16'sd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex1_x;
    logic signed [CoordW-1:0] vertex1_y;
    logic signed [CoordW-1:0] vertex2_x;
    logic signed [CoordW-1:0] vertex2_y;
    logic signed [CoordW-1:0] vertex3_x;
    logic signed [CoordW-1:0] vertex3_y;
    logic signed [CoordW-1:0] vertex4_x;
    logic signed [CoordW-1:0] vertex4_y;
    logic signed [CoordW-1:0] pivot_x;
    logic signed [CoordW-1:0] pivot_y;
    logic signed [AngleW-1:0] turn_angle;
  } quad_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rotated1_x;
    logic signed [CoordW-1:0] rotated1_y;
    logic signed [CoordW-1:0] rotated2_x;
    logic signed [CoordW-1:0] rotated2_y;
    logic signed [CoordW-1:0] rotated3_x;
    logic signed [CoordW-1:0] rotated3_y;
    logic signed [CoordW-1:0] rotated4_x;
    logic signed [CoordW-1:0] rotated4_y;
  } quad_out_t;

  function automatic logic signed [CordW-1:0] atan_q30(input int i);
    logic signed [CordW-1:0] r;
    case (i)
      0: r = 36'sd843314857;   1: r = 36'sd497837829;
      2: r = 36'sd263043837;   3: r = 36'sd133525159;
      4: r = 36'sd67021687;    5: r = 36'sd33543516;
      6: r = 36'sd16775851;    7: r = 36'sd8388437;
      8: r = 36'sd4194283;     9: r = 36'sd2097149;
      default: r = CordW'(36'sd1073741824 >>> i);
    endcase
    return r;
  endfunction

endpackage

/* design/qrap_cordic.sv */
// Pipelined rotation-mode CORDIC giving Q1.14 cos and sin, with a sideband that advances and stalls with it.
module qrap_cordic #(
  parameter int Stages = 16,
  parameter int SideW  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [qrap_pkg::AngleW-1:0] angle,
  input  logic [SideW-1:0] side_in,
  output logic out_valid,
  output logic signed [qrap_pkg::TrigW-1:0] cos_q14,
  output logic signed [qrap_pkg::TrigW-1:0] sin_q14,
  output logic [SideW-1:0] side_out
);
  import qrap_pkg::*;

  localparam int N = (Stages > AtanLen) ? AtanLen : Stages;

  logic signed [CordW-1:0] xs [N+1];
  logic signed [CordW-1:0] ys [N+1];
  logic signed [CordW-1:0] zs [N+1];
  logic                    fl [N+1];
  logic                    vs [N+1];
  logic [SideW-1:0]        sd [N+1];
  logic signed [CordW-1:0] z0;

  assign z0 = CordW'(angle) <<< 17;

  // stage 0 register: quarter-turn fold
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
    if (en) begin
      xs[0] <= GainQ30;
      ys[0] <= '0;
      sd[0] <= side_in;
      if (z0 > HalfPiQ30) begin
        zs[0] <= z0 - PiQ30;
        fl[0] <= 1'b1;
      end else if (z0 < -HalfPiQ30) begin
        zs[0] <= z0 + PiQ30;
        fl[0] <= 1'b1;
      end else begin
        zs[0] <= z0;
        fl[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        fl[i+1] <= fl[i];
        sd[i+1] <= sd[i];
        if (!zs[i][CordW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(i);
        end
      end
    end
  end

  function automatic logic signed [TrigW-1:0] to_q14(input logic signed [CordW-1:0] v,
                                                     input logic neg);
    logic signed [CordW-1:0] r;
    logic signed [TrigW-1:0] c;
    r = (v + CordW'(36'sd32768)) >>> 16;
    if (r > CordW'(TrigOne)) c = TrigOne;
    else if (r < -CordW'(TrigOne)) c = -TrigOne;
    else c = r[TrigW-1:0];
    return neg ? -c : c;
  endfunction

  assign cos_q14   = to_q14(xs[N], fl[N]);
  assign sin_q14   = to_q14(ys[N], fl[N]);
  assign out_valid = vs[N];
  assign side_out  = sd[N];
  // zs[N] is the residual angle and is not needed further
  logic unused_z;
  assign unused_z = ^zs[N];
endmodule

/* design/qrap_lane.sv */
// One vertex lane: offset, two-stage multiply-accumulate, round, re-add pivot, saturate.
module qrap_lane (
  input  logic clk,
  input  logic en,
  input  logic signed [qrap_pkg::CoordW-1:0] vx,
  input  logic signed [qrap_pkg::CoordW-1:0] vy,
  input  logic signed [qrap_pkg::CoordW-1:0] px,
  input  logic signed [qrap_pkg::CoordW-1:0] py,
  input  logic signed [qrap_pkg::TrigW-1:0] c,
  input  logic signed [qrap_pkg::TrigW-1:0] s,
  output logic signed [qrap_pkg::CoordW-1:0] rx,
  output logic signed [qrap_pkg::CoordW-1:0] ry
);
  import qrap_pkg::*;

  localparam int DW = CoordW + 1;
  localparam int PW = DW + TrigW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] dx, dy;
  logic signed [TrigW-1:0] c1, s1;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [CoordW-1:0] px1, py1, px2, py2;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [SW-1:0] rnd_x, rnd_y;

  // cos and sin travel with the offsets so both reach the multipliers together
  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= DW'(vx) - DW'(px);
      dy  <= DW'(vy) - DW'(py);
      c1  <= c;
      s1  <= s;
      px1 <= px;
      py1 <= py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= PW'(dx) * PW'(c1);
      p_ys <= PW'(dy) * PW'(s1);
      p_xs <= PW'(dx) * PW'(s1);
      p_yc <= PW'(dy) * PW'(c1);
      px2  <= px1;
      py2  <= py1;
    end
  end

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SW'(24'sh7FFFFF)) return 24'sh7FFFFF;
    if (v < -SW'(25'sd8388608)) return 24'sh800000;
    return v[CoordW-1:0];
  endfunction

  assign sum_x = SW'(p_xc) - SW'(p_ys);
  assign sum_y = SW'(p_xs) + SW'(p_yc);
  assign rnd_x = ((sum_x + SW'(16'sd8192)) >>> 14) + SW'(px2);
  assign rnd_y = ((sum_y + SW'(16'sd8192)) >>> 14) + SW'(py2);

  always_ff @(posedge clk) begin
    if (en) begin
      rx <= sat(rnd_x);
      ry <= sat(rnd_y);
    end
  end
endmodule

/* design/quad_rotate_about_pivot_core.sv */
// Top level: CORDIC front end, four vertex lanes and the merged output word.
// Quad rotation about a pivot. One quad word is taken every clock while the
// output is not stalled; each word passes through the CORDIC pipeline (fold register
// plus one per stage, CORDIC_STAGES capped at 24) and then the lane offset,
// multiply and round stages. The whole pipeline advances together and freezes
// while stall is held on a full output; in_stall is raised exactly then, whether
// or not earlier pipeline slots hold a word.
module quad_rotate_about_pivot_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  qrap_pkg::quad_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output qrap_pkg::quad_out_t out_data
);
  import qrap_pkg::*;

  localparam int SideW = 10 * CoordW;
  localparam int LaneLat = 3;

  logic en;
  logic cv;
  logic signed [TrigW-1:0] c, s;
  logic [SideW-1:0] side_o;
  logic [LaneLat-1:0] lv;
  quad_in_t q;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  qrap_cordic #(.Stages(CORDIC_STAGES), .SideW(SideW)) u_cordic (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .angle    (in_data.turn_angle),
    .side_in  (in_data[SideW+AngleW-1:AngleW]),
    .out_valid(cv),
    .cos_q14  (c),
    .sin_q14  (s),
    .side_out (side_o)
  );

  assign q = {side_o, {AngleW{1'b0}}};

  qrap_lane u_l1 (.clk, .en, .vx(q.vertex1_x), .vy(q.vertex1_y), .px(q.pivot_x),
    .py(q.pivot_y), .c, .s, .rx(out_data.rotated1_x), .ry(out_data.rotated1_y));
  qrap_lane u_l2 (.clk, .en, .vx(q.vertex2_x), .vy(q.vertex2_y), .px(q.pivot_x),
    .py(q.pivot_y), .c, .s, .rx(out_data.rotated2_x), .ry(out_data.rotated2_y));
  qrap_lane u_l3 (.clk, .en, .vx(q.vertex3_x), .vy(q.vertex3_y), .px(q.pivot_x),
    .py(q.pivot_y), .c, .s, .rx(out_data.rotated3_x), .ry(out_data.rotated3_y));
  qrap_lane u_l4 (.clk, .en, .vx(q.vertex4_x), .vy(q.vertex4_y), .px(q.pivot_x),
    .py(q.pivot_y), .c, .s, .rx(out_data.rotated4_x), .ry(out_data.rotated4_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= '0;
    end else if (en) begin
      lv <= {lv[LaneLat-2:0], cv};
    end
  end

  assign out_valid = lv[LaneLat-1];
endmodule

/* design/qrap_check.sv */
// Port-level checks for the quad rotation core, bound to the top level.
module qrap_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input qrap_pkg::quad_out_t out_data,
  input logic out_valid,
  input logic out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input open while output blocked");
  logic unused;
  assign unused = in_valid;
endmodule

bind quad_rotate_about_pivot_core qrap_check u_qrap_check (
  .clk, .rst, .in_valid, .in_stall, .out_data, .out_valid, .out_stall
);

/* bench/tb_quad_rotate_about_pivot_core.sv */
// Testbench for the quad rotation core: directed table, random quads, predicted results.
module tb_quad_rotate_about_pivot_core;
  import qrap_pkg::*;

  localparam int Stages = 16;
  localparam int Latency = Stages + 4;
  localparam int RandItems = 1150;
  localparam int NumDirected = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  quad_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  quad_out_t out_data;

  quad_out_t rotated_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int saturated = 0;

  quad_rotate_about_pivot_core #(.CORDIC_STAGES(Stages)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v < 0) return ~((~v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 843314857;  1: return 497837829;  2: return 263043837;
      3: return 133525159;  4: return 67021687;   5: return 33543516;
      6: return 16775851;   7: return 8388437;    8: return 4194283;
      9: return 2097149;
      default: return longint'(1) << (30 - i);
    endcase
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // cos and sin in Q1.14 from the gain-compensated CORDIC
  function automatic void trig_q14(input logic signed [AngleW-1:0] ang,
                                   output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    int n;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    n = (Stages > 24) ? 24 : Stages;
    if (z > 1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    c = clip(floor_shr(x + 32768, 16), -16384, 16384);
    s = clip(floor_shr(y + 32768, 16), -16384, 16384);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic quad_out_t rotate_quad(quad_in_t q);
    quad_out_t r;
    longint c, s, px, py, dx, dy, rx, ry;
    logic [CoordW-1:0] vx[4], vy[4], ox[4], oy[4];
    trig_q14(q.turn_angle, c, s);
    px = longint'(q.pivot_x);
    py = longint'(q.pivot_y);
    vx = '{q.vertex1_x, q.vertex2_x, q.vertex3_x, q.vertex4_x};
    vy = '{q.vertex1_y, q.vertex2_y, q.vertex3_y, q.vertex4_y};
    for (int k = 0; k < 4; k++) begin
      dx = longint'($signed(vx[k])) - px;
      dy = longint'($signed(vy[k])) - py;
      rx = clip(floor_shr(dx * c - dy * s + 8192, 14) + px, -8388608, 8388607);
      ry = clip(floor_shr(dx * s + dy * c + 8192, 14) + py, -8388608, 8388607);
      ox[k] = rx[CoordW-1:0];
      oy[k] = ry[CoordW-1:0];
    end
    r = {ox[0], oy[0], ox[1], oy[1], ox[2], oy[2], ox[3], oy[3]};
    return r;
  endfunction

  function automatic logic [CoordW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      1: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic quad_in_t rnd_quad();
    quad_in_t q;
    q = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 16'h0};
    // mostly legal angles, some raw 16-bit values beyond pi
    if ($urandom_range(0, 9) == 0) q.turn_angle = 16'($urandom);
    else q.turn_angle = 16'($signed($urandom_range(0, 51472)) - 25736);
    return q;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // directed table; expected typed in only where obvious
  quad_in_t dir_word[NumDirected];
  quad_out_t dir_rot[NumDirected];
  bit dir_known[NumDirected];

  task automatic send_word(input quad_in_t q, input quad_out_t exp_r, input bit known);
    in_data <= q;
    in_valid <= 1'b1;
    rotated_q.insert(rotated_q.size(), known ? exp_r : rotate_quad(q));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    quad_in_t q;
    for (int i = 0; i < NumDirected; i++) begin
      dir_word[i] = '0;
      dir_rot[i] = '0;
      dir_known[i] = 1'b0;
    end
    // all zero: output zero
    dir_known[0] = 1'b1;
    // angle zero: identity on a spread of points
    dir_word[1] = {24'sd256, -24'sd512, 24'h7fffff, 24'h800000, -24'sd1, 24'sd1,
                   24'sd1000, 24'sd0, 24'sd100, -24'sd100, 16'sd0};
    dir_rot[1] = dir_word[1][64 +: 192];
    dir_known[1] = 1'b1;
    // vertices equal to the pivot stay put at any angle
    dir_word[2] = {{8{24'sd12345}}, 24'sd12345, 24'sd12345, 16'sd9000};
    dir_rot[2] = {8{24'sd12345}};
    dir_known[2] = 1'b1;
    dir_word[3] = {24'sd2560, 24'sd0, 24'sd0, 24'sd2560, -24'sd2560, 24'sd0,
                   24'sd0, -24'sd2560, 24'sd0, 24'sd0, 16'sd12868};
    dir_word[4] = dir_word[3]; dir_word[4].turn_angle = -16'sd12868;
    dir_word[5] = dir_word[3]; dir_word[5].turn_angle = 16'sd25736;
    dir_word[6] = dir_word[3]; dir_word[6].turn_angle = -16'sd25736;
    dir_word[7] = dir_word[3]; dir_word[7].turn_angle = 16'sd12869;
    dir_word[8] = dir_word[3]; dir_word[8].turn_angle = 16'sh7fff;
    dir_word[9] = dir_word[3]; dir_word[9].turn_angle = 16'sh8000;
    // saturation in both directions
    dir_word[10] = {24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                    24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000, 16'sd6434};
    dir_word[11] = dir_word[10]; dir_word[11].pivot_x = 24'h7fffff;
    dir_word[11].pivot_y = 24'h7fffff; dir_word[11].turn_angle = 16'sd25736;
    dir_word[12] = {{8{24'hffffff}}, 24'h555555, 24'haaaaaa, 16'sh5555};
    dir_word[13] = {{8{24'h555555}}, 24'haaaaaa, 24'h555555, 16'shaaaa};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NumDirected; i++) send_word(dir_word[i], dir_rot[i], dir_known[i]);
    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) begin
        // drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (rotated_q.size() != 0) @(posedge clk);
      end else if (i > 200 && i < 300) begin
        // back-to-back stretch
      end else begin
        idle_for(gap_len());
      end
      q = rnd_quad();
      send_word(q, '0, 1'b0);
    end
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d quads (%0d directed), %0d results checked, %0d saturated coords.",
             words_in, NumDirected, words_out, saturated);
    $display("Angles covered both quarter-turn folds and raw values past pi.");
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver stall: short bursts mostly, a few long, quiet stretches too
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = gap_len();
      if ($urandom_range(0, 3) == 0) n = 0;
      out_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    quad_out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (rotated_q.size() == 0) begin
        $display("%0t: result word with nothing expected: %h", $time, out_data);
        errors++;
      end else begin
        exp_r = rotated_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (out_data[k*24 +: 24] inside {24'h7fffff, 24'h800000}) saturated++;
          if (out_data[k*24 +: 24] !== exp_r[k*24 +: 24]) begin
            $display("%0t: coord %0d (from msb %0d) expected %h actual %h", $time, k,
                     7 - k, exp_r[k*24 +: 24], out_data[k*24 +: 24]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", rotated_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
